/* rtl/ksl_pkg.sv */
// ----------------------------------------------------------------------------
// Key slot table package
// Shared sizes, codes and types of the key slot table.
// ----------------------------------------------------------------------------
package ksl_pkg;

	// Table size and derived widths.
	localparam int SLOTS = 4;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SCAN_W = IDX_W + 1;

	// Operation kinds.
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	// Result codes.
	localparam logic [1:0] RC_OK       = 2'd0;
	localparam logic [1:0] RC_INVALID  = 2'd1;
	localparam logic [1:0] RC_MISMATCH = 2'd2;
	localparam logic [1:0] RC_NO_SPACE = 2'd3;

	// Slot status codes.
	localparam logic [1:0] ST_EMPTY    = 2'd0;
	localparam logic [1:0] ST_ACTIVE   = 2'd1;
	localparam logic [1:0] ST_RETIRING = 2'd2;

	// Outcome of the shared comparator.
	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

endpackage

/* rtl/ksl_cmp_unit.sv */
// ----------------------------------------------------------------------------
// Key slot table comparator
// Shared 64-bit equality and signed less-than compare used by the sequencer.
// ----------------------------------------------------------------------------
module ksl_cmp_unit (
	input  logic [63:0]      a,
	input  logic [63:0]      b,
	output ksl_pkg::cmp_res_t res
);

	// Equality for identifier checks, signed order for the window checks.
	always_comb begin
		res.eq = (a == b);
		res.lt = ($signed(a) < $signed(b));
	end

endmodule

/* rtl/key_slot_table_with_validity.sv */
// ----------------------------------------------------------------------------
// Key slot table with validity windows
// Holds key identifiers with status and a signed validity window per slot.
// ----------------------------------------------------------------------------
// Each transaction is handled by a small sequencer around one shared 64-bit
// comparator: an optional identifier check (add with a claimed identifier),
// a scan of the slots one per cycle that stops at the first match, two
// window compares for a lookup hit, and a finishing state that writes the
// table and loads the result register once that register is free. An item
// occupies the block from acceptance until it leaves the finishing state,
// and in_stall stays high meanwhile. The result register lets a new
// transaction start while the previous result still waits to be taken.
module key_slot_table_with_validity (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [63:0]        key_id,
	input  logic               key_id_given,
	input  logic [63:0]        derived_id,
	input  logic signed [63:0] start_time,
	input  logic signed [63:0] end_time,
	input  logic [1:0]         new_status,
	input  logic signed [63:0] now_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_code,
	output logic               hit,
	output logic [1:0]         slot_index,
	output logic [1:0]         entry_status,
	output logic               valid_now,
	output logic signed [63:0] entry_start,
	output logic signed [63:0] entry_end,
	output logic [2:0]         entry_count
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_VERIFY = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_WIN_LO = 3'd3;
	localparam logic [2:0] S_WIN_HI = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]  state_q;
	logic [1:0]  kind_q;
	logic [63:0] key_q;
	logic        given_q;
	logic [63:0] derived_q;
	logic [63:0] start_q;
	logic [63:0] end_q;
	logic [1:0]  status_q;
	logic [63:0] now_q;

	logic                      pre_err_q;
	logic [1:0]                pre_code_q;
	logic [ksl_pkg::SCAN_W-1:0] scan_q;
	logic                      found_q;
	logic [ksl_pkg::IDX_W-1:0] match_q;
	logic                      empty_found_q;
	logic [ksl_pkg::IDX_W-1:0] empty_q;
	logic                      bad_lo_q;
	logic                      valid_q;

	logic [1:0]  slot_state_q [ksl_pkg::SLOTS];
	logic [63:0] slot_id_q    [ksl_pkg::SLOTS];
	logic [63:0] slot_start_q [ksl_pkg::SLOTS];
	logic [63:0] slot_end_q   [ksl_pkg::SLOTS];
	logic [2:0]  count_q;

	logic                      in_acc;
	logic                      out_free;
	logic [ksl_pkg::IDX_W-1:0] scan_idx;
	logic                      scan_last;
	logic [63:0]               search_id;
	logic                      slot_match;
	logic                      slot_empty;
	logic [63:0]               cmp_a;
	logic [63:0]               cmp_b;
	ksl_pkg::cmp_res_t         cmp;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign scan_idx  = scan_q[ksl_pkg::IDX_W-1:0];
	assign scan_last = (scan_q == ksl_pkg::SCAN_W'(ksl_pkg::SLOTS - 1));
	assign search_id = (kind_q == ksl_pkg::KIND_ADD) ? derived_q : key_q;

	// Operand selection for the shared comparator.
	always_comb begin
		unique case (state_q)
			S_VERIFY: begin
				cmp_a = key_q;
				cmp_b = derived_q;
			end
			S_WIN_LO: begin
				cmp_a = now_q;
				cmp_b = slot_start_q[match_q];
			end
			S_WIN_HI: begin
				cmp_a = slot_end_q[match_q];
				cmp_b = now_q;
			end
			default: begin
				cmp_a = slot_id_q[scan_idx];
				cmp_b = search_id;
			end
		endcase
	end

	ksl_cmp_unit u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	assign slot_empty = (slot_state_q[scan_idx] == ksl_pkg::ST_EMPTY);
	assign slot_match = !slot_empty && cmp.eq;

	// Sequencer and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (kind == ksl_pkg::KIND_ADD) begin
							if (new_status != ksl_pkg::ST_ACTIVE &&
							    new_status != ksl_pkg::ST_RETIRING) begin
								state_q <= S_FINISH;
							end else if (key_id_given) begin
								state_q <= S_VERIFY;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (kind == ksl_pkg::KIND_REMOVE ||
						             kind == ksl_pkg::KIND_LOOKUP) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_VERIFY: begin
					state_q <= cmp.eq ? S_SCAN : S_FINISH;
				end
				S_SCAN: begin
					if (slot_match) begin
						state_q <= (kind_q == ksl_pkg::KIND_LOOKUP) ? S_WIN_LO : S_FINISH;
					end else if (scan_last) begin
						state_q <= S_FINISH;
					end
				end
				S_WIN_LO: begin
					state_q <= S_WIN_HI;
				end
				S_WIN_HI: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Transaction capture and per-item working registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q        <= kind;
			key_q         <= key_id;
			given_q       <= key_id_given;
			derived_q     <= derived_id;
			start_q       <= start_time;
			end_q         <= end_time;
			status_q      <= new_status;
			now_q         <= now_time;
			scan_q        <= '0;
			found_q       <= 1'b0;
			empty_found_q <= 1'b0;
			valid_q       <= 1'b0;
			pre_err_q     <= 1'b0;
			pre_code_q    <= ksl_pkg::RC_INVALID;
			if (kind == ksl_pkg::KIND_ADD && new_status != ksl_pkg::ST_ACTIVE &&
			    new_status != ksl_pkg::ST_RETIRING) begin
				pre_err_q <= 1'b1;
			end
		end
		if (state_q == S_VERIFY && given_q && !cmp.eq) begin
			pre_err_q  <= 1'b1;
			pre_code_q <= ksl_pkg::RC_MISMATCH;
		end
		if (state_q == S_SCAN) begin
			scan_q <= scan_q + 1'b1;
			if (slot_match) begin
				found_q <= 1'b1;
				match_q <= scan_idx;
			end
			if (slot_empty && !empty_found_q) begin
				empty_found_q <= 1'b1;
				empty_q       <= scan_idx;
			end
		end
		// A zero bound means that side of the window is open.
		if (state_q == S_WIN_LO) begin
			bad_lo_q <= (slot_start_q[match_q] != 64'd0) && cmp.lt;
		end
		if (state_q == S_WIN_HI) begin
			valid_q <= !bad_lo_q && !((slot_end_q[match_q] != 64'd0) && cmp.lt);
		end
	end

	// Table status and occupancy; written in the finishing cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ksl_pkg::SLOTS; i++) begin
				slot_state_q[i] <= ksl_pkg::ST_EMPTY;
			end
			count_q <= '0;
		end else if (state_q == S_FINISH && out_free && !pre_err_q) begin
			if (kind_q == ksl_pkg::KIND_ADD) begin
				if (found_q) begin
					slot_state_q[match_q] <= status_q;
				end else if (empty_found_q) begin
					slot_state_q[empty_q] <= status_q;
					count_q               <= count_q + 3'd1;
				end
			end else if (kind_q == ksl_pkg::KIND_REMOVE && found_q) begin
				slot_state_q[match_q] <= ksl_pkg::ST_EMPTY;
				count_q               <= count_q - 3'd1;
			end
		end
	end

	// Slot payload; a removed slot is cleared to zero.
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free && !pre_err_q) begin
			if (kind_q == ksl_pkg::KIND_ADD) begin
				if (found_q) begin
					slot_id_q[match_q]    <= derived_q;
					slot_start_q[match_q] <= start_q;
					slot_end_q[match_q]   <= end_q;
				end else if (empty_found_q) begin
					slot_id_q[empty_q]    <= derived_q;
					slot_start_q[empty_q] <= start_q;
					slot_end_q[empty_q]   <= end_q;
				end
			end else if (kind_q == ksl_pkg::KIND_REMOVE && found_q) begin
				slot_id_q[match_q]    <= '0;
				slot_start_q[match_q] <= '0;
				slot_end_q[match_q]   <= '0;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload; error results carry zero fields apart from the code and the entry count.
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			result_code  <= ksl_pkg::RC_INVALID;
			hit          <= 1'b0;
			slot_index   <= '0;
			entry_status <= ksl_pkg::ST_EMPTY;
			valid_now    <= 1'b0;
			entry_start  <= '0;
			entry_end    <= '0;
			entry_count  <= count_q;
			if (pre_err_q) begin
				result_code <= pre_code_q;
			end else if (kind_q == ksl_pkg::KIND_ADD) begin
				if (found_q || empty_found_q) begin
					result_code  <= ksl_pkg::RC_OK;
					hit          <= 1'b1;
					slot_index   <= 2'(found_q ? match_q : empty_q);
					entry_status <= status_q;
					entry_start  <= start_q;
					entry_end    <= end_q;
					entry_count  <= found_q ? count_q : count_q + 3'd1;
				end else begin
					result_code <= ksl_pkg::RC_NO_SPACE;
				end
			end else if (kind_q == ksl_pkg::KIND_REMOVE) begin
				if (found_q) begin
					result_code <= ksl_pkg::RC_OK;
					hit         <= 1'b1;
					slot_index  <= 2'(match_q);
					entry_count <= count_q - 3'd1;
				end
			end else if (kind_q == ksl_pkg::KIND_LOOKUP) begin
				if (found_q) begin
					result_code  <= ksl_pkg::RC_OK;
					hit          <= 1'b1;
					slot_index   <= 2'(match_q);
					entry_status <= slot_state_q[match_q];
					valid_now    <= valid_q;
					entry_start  <= slot_start_q[match_q];
					entry_end    <= slot_end_q[match_q];
				end
			end
		end
	end

endmodule
